// ===== hdl/lra_pkg.sv =====
`default_nettype none

package lra_pkg;

  // ring geometry and animation constants
  localparam int RING_PIXELS   = 16;
  localparam int BREATHE_TICKS = 200;
  localparam int TAIL_LENGTH   = 4;

  localparam int PIX_W    = $clog2(RING_PIXELS);
  localparam int BRE_W    = $clog2(BREATHE_TICKS);
  localparam int BRE_STEP = 64 / BREATHE_TICKS;
  localparam int BRE_REM  = 64 % BREATHE_TICKS;
  localparam int LVL_W    = $clog2(RING_PIXELS * 200 + 101);

  // descriptor queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // register reset values
  localparam logic [15:0] LEVEL_HOLD_RST = 16'd2000;
  localparam logic [9:0]  FLASH_HALF_RST = 10'd120;
  localparam logic [9:0]  ERROR_HALF_RST = 10'd150;

  localparam logic [7:0]  LEVEL_MAX  = 8'd100;
  localparam logic [8:0]  GAIN_UNITY = 9'd256;
  localparam logic [8:0]  GAIN_DIM   = 9'd16;
  localparam logic [8:0]  GAIN_ZERO  = 9'd0;
  localparam logic [23:0] RGB_BLACK  = 24'h000000;
  localparam logic [23:0] RGB_RED    = 24'hFF0000;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_IDLE   = 3'd1,
    CMD_SHOW_LEVEL = 3'd2,
    CMD_FEEDBACK   = 3'd3,
    CMD_OFF        = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_LEVEL_HOLD = 2'd0,
    CFG_FLASH_HALF = 2'd1,
    CFG_ERROR_HALF = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    IDLE_OFF     = 2'd0,
    IDLE_BREATHE = 2'd1,
    IDLE_SOLID   = 2'd2
  } idle_mode_t;

  typedef enum logic [2:0] {
    FB_NONE  = 3'd0,
    FB_CW    = 3'd1,
    FB_CCW   = 3'd2,
    FB_FLASH = 3'd3,
    FB_ERROR = 3'd4
  } fb_mode_t;

  typedef enum logic [1:0] {
    DK_FILL  = 2'd0,
    DK_LEVEL = 2'd1,
    DK_CW    = 2'd2,
    DK_CCW   = 2'd3
  } desc_kind_t;

  typedef enum logic {
    FS_ACCEPT = 1'b0,
    FS_DIVIDE = 1'b1
  } front_state_t;

  // one frame to render, as the back end needs it
  typedef struct packed {
    desc_kind_t        kind;
    logic [23:0]       rgb;
    logic [8:0]        gain;
    logic [PIX_W-1:0]  head;
    logic [LVL_W-1:0]  thr;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic busy;
    logic odd;
  } div_stat_t;

  // first half of the breathe curve, in 1/256 units
  function automatic logic [8:0] gain_half(input logic [5:0] p);
    logic [8:0] g;
    unique case (p)
      6'd0:  g = 9'd13;
      6'd1:  g = 9'd13;
      6'd2:  g = 9'd15;
      6'd3:  g = 9'd18;
      6'd4:  g = 9'd22;
      6'd5:  g = 9'd27;
      6'd6:  g = 9'd33;
      6'd7:  g = 9'd40;
      6'd8:  g = 9'd48;
      6'd9:  g = 9'd57;
      6'd10: g = 9'd67;
      6'd11: g = 9'd77;
      6'd12: g = 9'd88;
      6'd13: g = 9'd99;
      6'd14: g = 9'd111;
      6'd15: g = 9'd122;
      6'd16: g = 9'd134;
      6'd17: g = 9'd146;
      6'd18: g = 9'd158;
      6'd19: g = 9'd170;
      6'd20: g = 9'd181;
      6'd21: g = 9'd192;
      6'd22: g = 9'd202;
      6'd23: g = 9'd212;
      6'd24: g = 9'd220;
      6'd25: g = 9'd228;
      6'd26: g = 9'd236;
      6'd27: g = 9'd242;
      6'd28: g = 9'd247;
      6'd29: g = 9'd251;
      6'd30: g = 9'd254;
      6'd31: g = 9'd255;
      6'd32: g = 9'd256;
      default: g = 9'd0;
    endcase
    return g;
  endfunction

  // comet tail fade, 255 - 55 * distance from the head
  function automatic logic [8:0] tail_gain(input logic [1:0] t);
    logic [8:0] g;
    unique case (t)
      2'd0: g = 9'd255;
      2'd1: g = 9'd200;
      2'd2: g = 9'd145;
      2'd3: g = 9'd90;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lra_div.sv =====
`default_nettype none

module lra_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [31:0]         dividend,
  input  wire logic [9:0]          divisor,
  output lra_pkg::div_stat_t       stat
);

  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic             busy_r, busy_nxt;
  logic             odd_r, odd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [9:0]       rem_r, rem_nxt;
  logic [31:0]      dvd_r, dvd_nxt;
  logic [9:0]       d_r, d_nxt;

  logic [11:0] partial;
  logic [11:0] d1, d2, d3;
  logic [11:0] sub;
  logic [1:0]  digit;

  // radix-4 restoring step: two quotient bits per cycle
  always_comb begin
    partial = {rem_r, dvd_r[31:30]};
    d1      = {2'b00, d_r};
    d2      = {1'b0, d_r, 1'b0};
    d3      = d1 + d2;
    priority if (partial >= d3) begin
      digit = 2'd3;
      sub   = d3;
    end else if (partial >= d2) begin
      digit = 2'd2;
      sub   = d2;
    end else if (partial >= d1) begin
      digit = 2'd1;
      sub   = d1;
    end else begin
      digit = 2'd0;
      sub   = 12'd0;
    end
  end

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    odd_nxt  = odd_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      d_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt = 10'(partial - sub);
      dvd_nxt = {dvd_r[29:0], 2'b00};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        odd_nxt  = digit[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odd_r <= odd_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    d_r   <= d_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.odd  = odd_r;

endmodule

`default_nettype wire

// ===== hdl/lra_front.sv =====
`default_nettype none

module lra_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command word
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [2:0]           in_command,
  input  wire logic [31:0]          in_now,
  input  wire logic [2:0]           in_anim,
  input  wire logic [23:0]          in_rgb,
  input  wire logic [7:0]           in_pct,
  input  wire logic [31:0]          in_dur,
  // register writes
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  // descriptor queue
  input  wire lra_pkg::queue_stat_t q_stat,
  output logic                      desc_push,
  output lra_pkg::frame_desc_t      desc
);

  localparam int N = lra_pkg::RING_PIXELS;
  localparam int B = lra_pkg::BREATHE_TICKS;
  localparam int PW = lra_pkg::PIX_W;
  localparam int BW = lra_pkg::BRE_W;
  localparam int LW = lra_pkg::LVL_W;

  lra_pkg::front_state_t state_r, state_nxt;

  logic [15:0] hold_r, hold_nxt;
  logic [9:0]  flash_half_r, flash_half_nxt;
  logic [9:0]  err_half_r, err_half_nxt;

  logic [31:0]   step_r, step_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [BW-1:0] bpos_r, bpos_nxt;
  logic [5:0]    bph_r, bph_nxt;
  logic [BW-1:0] brem_r, brem_nxt;

  lra_pkg::idle_mode_t idle_mode_r, idle_mode_nxt;
  logic [23:0]         idle_rgb_r, idle_rgb_nxt;
  logic                lvl_shown_r, lvl_shown_nxt;
  logic [LW-1:0]       lvl_thr_r, lvl_thr_nxt;
  logic [23:0]         lvl_rgb_r, lvl_rgb_nxt;
  logic [31:0]         lvl_exp_r, lvl_exp_nxt;
  lra_pkg::fb_mode_t   fb_mode_r, fb_mode_nxt;
  logic [23:0]         fb_rgb_r, fb_rgb_nxt;
  logic [31:0]         fb_start_r, fb_start_nxt;
  logic [31:0]         fb_len_r, fb_len_nxt;
  logic [23:0]         pend_rgb_r, pend_rgb_nxt;

  lra_pkg::cmd_t cmd;
  logic          acc;

  // tick evaluation
  logic          step_wrap;
  logic [PW-1:0] head_inc;
  logic          bpos_wrap;
  logic [BW-1:0] bpos_inc;
  logic [BW:0]   rem_sum;
  logic [5:0]    bph_inc;
  logic [BW-1:0] brem_inc;
  logic [31:0]   elapsed;
  logic [31:0]   lvl_diff;
  logic          fb_active;
  logic          fb_clear;
  logic          lvl_keep;
  logic [5:0]    bph_sel;
  logic [5:0]    bph_fold;
  logic          tick_div;
  logic [9:0]    half_sel;
  lra_pkg::frame_desc_t tick_desc;
  logic [7:0]    pct_sat;

  logic                 div_start;
  lra_pkg::div_stat_t   div_stat;

  assign cmd = lra_pkg::cmd_t'(in_command);
  assign acc = in_tvalid && in_tready;

  // step counter and its running residues
  always_comb begin
    step_wrap = &step_r;
    head_inc  = (step_wrap || head_r == PW'(N - 1)) ? '0 : head_r + PW'(1);
    bpos_wrap = step_wrap || (({1'b0, bpos_r} + (BW+1)'(1)) == (BW+1)'(B));
    bpos_inc  = bpos_wrap ? '0 : bpos_r + BW'(1);
    rem_sum   = {1'b0, brem_r} + (BW+1)'(lra_pkg::BRE_REM);
    if (bpos_wrap) begin
      bph_inc  = '0;
      brem_inc = '0;
    end else if (rem_sum >= (BW+1)'(B)) begin
      bph_inc  = bph_r + 6'(lra_pkg::BRE_STEP + 1);
      brem_inc = BW'(rem_sum - (BW+1)'(B));
    end else begin
      bph_inc  = bph_r + 6'(lra_pkg::BRE_STEP);
      brem_inc = BW'(rem_sum);
    end
  end

  // what a tick renders
  always_comb begin
    elapsed   = in_now - fb_start_r;
    lvl_diff  = in_now - lvl_exp_r;
    fb_active = (fb_mode_r != lra_pkg::FB_NONE) && (elapsed < fb_len_r);
    fb_clear  = (fb_mode_r != lra_pkg::FB_NONE) && !fb_active;
    lvl_keep  = lvl_shown_r && lvl_diff[31];
    bph_sel   = fb_clear ? 6'd0 : bph_inc;
    bph_fold  = (bph_sel > 6'd32) ? 6'(7'd64 - {1'b0, bph_sel}) : bph_sel;
    half_sel  = (fb_mode_r == lra_pkg::FB_FLASH) ? flash_half_r : err_half_r;
    if (half_sel == 10'd0) begin
      half_sel = 10'd1;
    end
    tick_div       = 1'b0;
    tick_desc.kind = lra_pkg::DK_FILL;
    tick_desc.rgb  = lra_pkg::RGB_BLACK;
    tick_desc.gain = lra_pkg::GAIN_ZERO;
    tick_desc.head = head_inc;
    tick_desc.thr  = lvl_thr_r;
    if (fb_active) begin
      unique case (fb_mode_r)
        lra_pkg::FB_CW: begin
          tick_desc.kind = lra_pkg::DK_CW;
          tick_desc.rgb  = fb_rgb_r;
        end
        lra_pkg::FB_CCW: begin
          tick_desc.kind = lra_pkg::DK_CCW;
          tick_desc.rgb  = fb_rgb_r;
        end
        lra_pkg::FB_FLASH, lra_pkg::FB_ERROR: begin
          tick_div = 1'b1;
        end
        default: begin
          tick_div = 1'b0;
        end
      endcase
    end else if (lvl_keep) begin
      tick_desc.kind = lra_pkg::DK_LEVEL;
      tick_desc.rgb  = lvl_rgb_r;
    end else begin
      unique case (idle_mode_r)
        lra_pkg::IDLE_BREATHE: begin
          tick_desc.rgb  = idle_rgb_r;
          tick_desc.gain = lra_pkg::gain_half(bph_fold);
        end
        lra_pkg::IDLE_SOLID: begin
          tick_desc.rgb  = idle_rgb_r;
          tick_desc.gain = lra_pkg::GAIN_UNITY;
        end
        default: begin
          tick_desc.rgb  = lra_pkg::RGB_BLACK;
        end
      endcase
    end
  end

  // state next
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lra_pkg::FS_ACCEPT: begin
        if (acc && cmd == lra_pkg::CMD_TICK && tick_div) begin
          state_nxt = lra_pkg::FS_DIVIDE;
        end
      end
      lra_pkg::FS_DIVIDE: begin
        if (!div_stat.busy && !q_stat.full) begin
          state_nxt = lra_pkg::FS_ACCEPT;
        end
      end
      default: state_nxt = lra_pkg::FS_ACCEPT;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    desc_push = 1'b0;
    div_start = 1'b0;
    desc      = tick_desc;
    unique case (state_r)
      lra_pkg::FS_ACCEPT: begin
        in_tready = !q_stat.full;
        if (acc && cmd == lra_pkg::CMD_OFF) begin
          desc_push = 1'b1;
          desc.kind = lra_pkg::DK_FILL;
          desc.rgb  = lra_pkg::RGB_BLACK;
          desc.gain = lra_pkg::GAIN_ZERO;
        end else if (acc && cmd == lra_pkg::CMD_TICK) begin
          desc_push = !tick_div;
          div_start = tick_div;
        end
      end
      lra_pkg::FS_DIVIDE: begin
        desc_push = !div_stat.busy && !q_stat.full;
        desc.kind = lra_pkg::DK_FILL;
        desc.rgb  = pend_rgb_r;
        desc.gain = div_stat.odd ? lra_pkg::GAIN_ZERO : lra_pkg::GAIN_UNITY;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // blink phase: quotient parity of elapsed time over the half period
  lra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (half_sel),
    .stat     (div_stat)
  );

  assign pct_sat = (in_pct > lra_pkg::LEVEL_MAX) ? lra_pkg::LEVEL_MAX : in_pct;

  // register writes and command effects
  always_comb begin
    hold_nxt       = hold_r;
    flash_half_nxt = flash_half_r;
    err_half_nxt   = err_half_r;
    step_nxt       = step_r;
    head_nxt       = head_r;
    bpos_nxt       = bpos_r;
    bph_nxt        = bph_r;
    brem_nxt       = brem_r;
    idle_mode_nxt  = idle_mode_r;
    idle_rgb_nxt   = idle_rgb_r;
    lvl_shown_nxt  = lvl_shown_r;
    lvl_thr_nxt    = lvl_thr_r;
    lvl_rgb_nxt    = lvl_rgb_r;
    lvl_exp_nxt    = lvl_exp_r;
    fb_mode_nxt    = fb_mode_r;
    fb_rgb_nxt     = fb_rgb_r;
    fb_start_nxt   = fb_start_r;
    fb_len_nxt     = fb_len_r;
    pend_rgb_nxt   = pend_rgb_r;

    if (cfg_valid) begin
      unique case (lra_pkg::cfg_idx_t'(cfg_index))
        lra_pkg::CFG_LEVEL_HOLD: hold_nxt       = cfg_data;
        lra_pkg::CFG_FLASH_HALF: flash_half_nxt = cfg_data[9:0];
        lra_pkg::CFG_ERROR_HALF: err_half_nxt   = cfg_data[9:0];
        default:                 hold_nxt       = hold_r;
      endcase
    end

    if (acc) begin
      unique case (cmd)
        lra_pkg::CMD_TICK: begin
          lvl_shown_nxt = lvl_keep;
          pend_rgb_nxt  = (fb_mode_r == lra_pkg::FB_FLASH) ? fb_rgb_r : lra_pkg::RGB_RED;
          if (fb_clear) begin
            fb_mode_nxt = lra_pkg::FB_NONE;
            step_nxt    = '0;
            head_nxt    = '0;
            bpos_nxt    = '0;
            bph_nxt     = '0;
            brem_nxt    = '0;
          end else begin
            step_nxt = step_r + 32'd1;
            head_nxt = head_inc;
            bpos_nxt = bpos_inc;
            bph_nxt  = bph_inc;
            brem_nxt = brem_inc;
          end
        end
        lra_pkg::CMD_SET_IDLE: begin
          idle_mode_nxt = (in_anim <= 3'(lra_pkg::IDLE_SOLID))
                          ? lra_pkg::idle_mode_t'(in_anim[1:0]) : lra_pkg::IDLE_OFF;
          idle_rgb_nxt  = in_rgb;
          step_nxt      = '0;
          head_nxt      = '0;
          bpos_nxt      = '0;
          bph_nxt       = '0;
          brem_nxt      = '0;
        end
        lra_pkg::CMD_SHOW_LEVEL: begin
          lvl_shown_nxt = 1'b1;
          lvl_thr_nxt   = LW'(pct_sat) * LW'(2 * N) + LW'(100);
          lvl_rgb_nxt   = in_rgb;
          lvl_exp_nxt   = in_now + {16'd0, hold_r};
        end
        lra_pkg::CMD_FEEDBACK: begin
          fb_mode_nxt  = (in_anim <= lra_pkg::FB_ERROR)
                         ? lra_pkg::fb_mode_t'(in_anim) : lra_pkg::FB_NONE;
          fb_rgb_nxt   = in_rgb;
          fb_start_nxt = in_now;
          fb_len_nxt   = in_dur;
        end
        lra_pkg::CMD_OFF: begin
          idle_mode_nxt = lra_pkg::IDLE_OFF;
          idle_rgb_nxt  = lra_pkg::RGB_BLACK;
        end
        default: begin
          step_nxt = step_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lra_pkg::FS_ACCEPT;
      hold_r       <= lra_pkg::LEVEL_HOLD_RST;
      flash_half_r <= lra_pkg::FLASH_HALF_RST;
      err_half_r   <= lra_pkg::ERROR_HALF_RST;
      step_r       <= '0;
      head_r       <= '0;
      bpos_r       <= '0;
      bph_r        <= '0;
      brem_r       <= '0;
      idle_mode_r  <= lra_pkg::IDLE_OFF;
      idle_rgb_r   <= lra_pkg::RGB_BLACK;
      lvl_shown_r  <= 1'b0;
      lvl_thr_r    <= LW'(100);
      lvl_rgb_r    <= lra_pkg::RGB_BLACK;
      lvl_exp_r    <= '0;
      fb_mode_r    <= lra_pkg::FB_NONE;
      fb_rgb_r     <= lra_pkg::RGB_BLACK;
      fb_start_r   <= '0;
      fb_len_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      hold_r       <= hold_nxt;
      flash_half_r <= flash_half_nxt;
      err_half_r   <= err_half_nxt;
      step_r       <= step_nxt;
      head_r       <= head_nxt;
      bpos_r       <= bpos_nxt;
      bph_r        <= bph_nxt;
      brem_r       <= brem_nxt;
      idle_mode_r  <= idle_mode_nxt;
      idle_rgb_r   <= idle_rgb_nxt;
      lvl_shown_r  <= lvl_shown_nxt;
      lvl_thr_r    <= lvl_thr_nxt;
      lvl_rgb_r    <= lvl_rgb_nxt;
      lvl_exp_r    <= lvl_exp_nxt;
      fb_mode_r    <= fb_mode_nxt;
      fb_rgb_r     <= fb_rgb_nxt;
      fb_start_r   <= fb_start_nxt;
      fb_len_r     <= fb_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_rgb_r <= pend_rgb_nxt;
  end

  // no command words while the blink phase is being worked out
  a_divide_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lra_pkg::FS_DIVIDE |-> !in_tready)
    else $error("front accepts a word while dividing");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_stat.busy && state_r == lra_pkg::FS_DIVIDE)
    else $error("divider not running after start");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> !q_stat.full)
    else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/lra_fifo.sv =====
`default_nettype none

module lra_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lra_pkg::frame_desc_t wr_desc,
  input  wire logic                 pop,
  output lra_pkg::frame_desc_t      rd_desc,
  output lra_pkg::queue_stat_t      stat
);

  localparam int D  = lra_pkg::QUEUE_DEPTH;
  localparam int PW = lra_pkg::QP_W;

  lra_pkg::frame_desc_t entry_r [D];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(D - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(D - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

  assign rd_desc    = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == (PW+1)'(D));
  assign stat.empty = (count_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(D))
    else $error("queue fill count out of range");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !stat.empty)
    else $error("queue empty right after a push");

endmodule

`default_nettype wire

// ===== hdl/lra_back.sv =====
`default_nettype none

module lra_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lra_pkg::frame_desc_t q_desc,
  input  wire lra_pkg::queue_stat_t q_stat,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [3:0]                out_index,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic                      out_tlast
);

  localparam int N  = lra_pkg::RING_PIXELS;
  localparam int PW = lra_pkg::PIX_W;
  localparam int LW = lra_pkg::LVL_W;

  logic [PW-1:0] pix_cnt_r, pix_cnt_nxt;

  // pixel select stage
  logic          s1_valid_r, s1_valid_nxt;
  logic [23:0]   s1_rgb_r;
  logic [8:0]    s1_k_r;
  logic [3:0]    s1_idx_r;
  logic          s1_last_r;

  // output word
  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_idx_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r;
  logic          out_last_r;

  logic          out_adv;
  logic          s1_take;
  logic          gen;
  logic          pix_last;

  logic [PW:0]   diff;
  logic [PW:0]   tail_dist;
  logic [PW-1:0] ccw_head;
  logic [LW-1:0] lit_bound;
  logic [8:0]    k_sel;

  logic [16:0]   prod_r, prod_g, prod_b;

  // handshake between stages
  always_comb begin
    out_adv  = !out_valid_r || out_tready;
    s1_take  = !s1_valid_r || out_adv;
    gen      = !q_stat.empty && s1_take;
    pix_last = (pix_cnt_r == PW'(N - 1));
    q_pop    = gen && pix_last;
  end

  // per-pixel gain
  always_comb begin
    ccw_head  = PW'(N - 1) - q_desc.head;
    if (q_desc.kind == lra_pkg::DK_CCW) begin
      diff = {1'b0, pix_cnt_r} - {1'b0, ccw_head};
    end else begin
      diff = {1'b0, q_desc.head} - {1'b0, pix_cnt_r};
    end
    tail_dist = diff[PW] ? diff + (PW+1)'(N) : diff;
    lit_bound = (LW'(pix_cnt_r) + LW'(1)) * LW'(200);
    unique case (q_desc.kind)
      lra_pkg::DK_CW, lra_pkg::DK_CCW: begin
        k_sel = (tail_dist < (PW+1)'(lra_pkg::TAIL_LENGTH))
                ? lra_pkg::tail_gain(2'(tail_dist)) : lra_pkg::GAIN_ZERO;
      end
      lra_pkg::DK_LEVEL: begin
        k_sel = (lit_bound <= q_desc.thr) ? lra_pkg::GAIN_UNITY : lra_pkg::GAIN_DIM;
      end
      default: begin
        k_sel = q_desc.gain;
      end
    endcase
  end

  // color scaling
  always_comb begin
    prod_r = 17'(s1_rgb_r[23:16]) * 17'(s1_k_r);
    prod_g = 17'(s1_rgb_r[15:8])  * 17'(s1_k_r);
    prod_b = 17'(s1_rgb_r[7:0])   * 17'(s1_k_r);
  end

  always_comb begin
    pix_cnt_nxt   = pix_cnt_r;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (gen) begin
      pix_cnt_nxt = pix_last ? '0 : pix_cnt_r + PW'(1);
    end
    if (gen) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pix_cnt_r   <= pix_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      s1_rgb_r  <= q_desc.rgb;
      s1_k_r    <= k_sel;
      s1_idx_r  <= 4'(pix_cnt_r);
      s1_last_r <= pix_last;
    end
    if (out_adv && s1_valid_r) begin
      out_idx_r   <= s1_idx_r;
      out_red_r   <= prod_r[15:8];
      out_green_r <= prod_g[15:8];
      out_blue_r  <= prod_b[15:8];
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_index  = out_idx_r;
  assign out_red    = out_red_r;
  assign out_green  = out_green_r;
  assign out_blue   = out_blue_r;
  assign out_tlast  = out_last_r;

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == 4'(N - 1))
    else $error("frame ends on the wrong pixel");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_valid_r && s1_last_r && pix_cnt_r == '0)
    else $error("descriptor released before its last pixel");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pix_cnt_r <= PW'(N - 1))
    else $error("pixel counter out of range");

endmodule

`default_nettype wire

// ===== hdl/led_ring_animation_engine.sv =====
// A tick or off word is written into the descriptor queue, and its first pixel then passes
// the pixel select and output registers; a tick that renders flash or error blinking first
// goes through the radix-4 phase divider. Throughput: one pixel per cycle while out_tready
// allows, set by the single pixel pipeline of the back end; a flash or error tick holds the
// input while its phase is divided; command words are taken only while the queue has room.
// Reset: rst_n is synchronous and active low; registers return to 2000, 120 and 150 ms
// and all animation state, the descriptor queue and the output valid flag are cleared.
`default_nettype none

module led_ring_animation_engine (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // command words
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // now_ms[31:0], anim_code[34:32], red_in[42:35], green_in[50:43],
  // blue_in[58:51], level_pct[66:59], duration_ms[98:67], zero pad[103:99]
  input  wire logic [103:0] in_tdata,
  // command[2:0]
  input  wire logic [2:0]   in_tuser,
  // pixel words
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pixel_index[3:0], pix_red[11:4], pix_green[19:12], pix_blue[27:20], zero pad[31:28]
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  lra_pkg::queue_stat_t q_stat;
  lra_pkg::frame_desc_t push_desc;
  lra_pkg::frame_desc_t head_desc;
  logic                 desc_push;
  logic                 q_pop;
  logic [3:0]           pix_index;
  logic [7:0]           pix_red, pix_green, pix_blue;

  assign cfg_ready = 1'b1;

  // command decode and animation state
  lra_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .in_now     (in_tdata[31:0]),
    .in_anim    (in_tdata[34:32]),
    .in_rgb     ({in_tdata[42:35], in_tdata[50:43], in_tdata[58:51]}),
    .in_pct     (in_tdata[66:59]),
    .in_dur     (in_tdata[98:67]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .desc_push  (desc_push),
    .desc       (push_desc)
  );

  // frame descriptors waiting for the renderer
  lra_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_push),
    .wr_desc (push_desc),
    .pop     (q_pop),
    .rd_desc (head_desc),
    .stat    (q_stat)
  );

  // pixel renderer
  lra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_desc     (head_desc),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_index  (pix_index),
    .out_red    (pix_red),
    .out_green  (pix_green),
    .out_blue   (pix_blue),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {4'b0000, pix_blue, pix_green, pix_red, pix_index};

endmodule

`default_nettype wire

// ===== tb/led_ring_frame_checker.sv =====
`timescale 1ns / 100ps

module led_ring_frame_checker
  import lra_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // now_ms, anim_code, red_in, green_in, blue_in, level_pct, duration_ms, pad
  input  wire logic [103:0] in_tdata,
  // command
  input  wire logic [2:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // pixel_index, pix_red, pix_green, pix_blue, pad
  input  wire logic [31:0]  out_tdata,
  input  wire logic         out_tlast,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output int unsigned       mismatches,
  output int unsigned       pending
);

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } ring_pixel_t;

  // breathe curve, entry 32 in the top bits down to entry 0 in the low bits
  localparam logic [33*9-1:0] BREATHE_CURVE = {
    9'd256, 9'd255, 9'd254, 9'd251, 9'd247, 9'd242, 9'd236, 9'd228, 9'd220,
    9'd212, 9'd202, 9'd192, 9'd181, 9'd170, 9'd158, 9'd146, 9'd134, 9'd122,
    9'd111, 9'd99,  9'd88,  9'd77,  9'd67,  9'd57,  9'd48,  9'd40,  9'd33,
    9'd27,  9'd22,  9'd18,  9'd15,  9'd13,  9'd13
  };

  // register copies
  logic [15:0] hold_ms;
  logic [9:0]  flash_half;
  logic [9:0]  error_half;

  // animation state
  logic [31:0] step_cnt;
  idle_mode_t  idle_mode;
  logic [23:0] idle_color;
  logic        lvl_on;
  logic [6:0]  lvl_val;
  logic [23:0] lvl_color;
  logic [31:0] lvl_expiry;
  fb_mode_t    fb_mode;
  logic [23:0] fb_color;
  logic [31:0] fb_start;
  logic [31:0] fb_len;

  logic [23:0] frame_buf [RING_PIXELS];
  ring_pixel_t expected_pixels [$];
  int unsigned miss_cnt;

  function automatic logic [23:0] scale_rgb(input logic [23:0] rgb, input logic [8:0] k);
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
    r = 17'(rgb[23:16]) * 17'(k);
    g = 17'(rgb[15:8]) * 17'(k);
    b = 17'(rgb[7:0]) * 17'(k);
    return {r[15:8], g[15:8], b[15:8]};
  endfunction

  task automatic fill_frame(input logic [23:0] rgb);
    for (int i = 0; i < RING_PIXELS; i++) frame_buf[i] = rgb;
  endtask

  task automatic push_frame();
    ring_pixel_t p;
    for (int i = 0; i < RING_PIXELS; i++) begin
      p.idx   = i[3:0];
      p.red   = frame_buf[i][23:16];
      p.green = frame_buf[i][15:8];
      p.blue  = frame_buf[i][7:0];
      p.last  = (i == RING_PIXELS - 1);
      expected_pixels.push_back(p);
    end
  endtask

  // advance the step, expire level and feedback, then draw by priority
  task automatic render_tick(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] since_expiry;
    logic [31:0] half;
    logic [31:0] head;
    logic [31:0] pos;
    logic [31:0] lit;
    logic [31:0] phase;
    logic [23:0] dim;
    logic [8:0]  fade;
    elapsed      = now - fb_start;
    since_expiry = now - lvl_expiry;
    step_cnt     = step_cnt + 32'd1;
    if (lvl_on && since_expiry < 32'h8000_0000) lvl_on = 1'b0;
    if (fb_mode != FB_NONE && elapsed < fb_len) begin
      case (fb_mode)
        FB_CW, FB_CCW: begin
          head = step_cnt % RING_PIXELS;
          if (fb_mode == FB_CCW) head = RING_PIXELS - 1 - head;
          fill_frame(RGB_BLACK);
          // comet tail trails the head against the direction of travel
          for (int t = 0; t < TAIL_LENGTH; t++) begin
            pos  = (fb_mode == FB_CW) ? (head + RING_PIXELS - t) % RING_PIXELS
                                      : (head + t) % RING_PIXELS;
            fade = 9'(255 - 55 * t);
            frame_buf[pos] = scale_rgb(fb_color, fade);
          end
        end
        FB_FLASH: begin
          half  = (flash_half == 10'd0) ? 32'd1 : {22'd0, flash_half};
          phase = elapsed / half;
          fill_frame(phase[0] ? RGB_BLACK : fb_color);
        end
        default: begin
          half  = (error_half == 10'd0) ? 32'd1 : {22'd0, error_half};
          phase = elapsed / half;
          fill_frame(phase[0] ? RGB_BLACK : RGB_RED);
        end
      endcase
    end else begin
      // finished feedback drops back and restarts the step count
      if (fb_mode != FB_NONE) begin
        fb_mode  = FB_NONE;
        step_cnt = 32'd0;
      end
      if (lvl_on) begin
        lit = (lvl_val * RING_PIXELS * 2 + 100) / 200;
        if (lit > RING_PIXELS) lit = RING_PIXELS;
        dim = {4'h0, lvl_color[23:20], 4'h0, lvl_color[15:12], 4'h0, lvl_color[7:4]};
        for (int i = 0; i < RING_PIXELS; i++) frame_buf[i] = (i < lit) ? lvl_color : dim;
      end else if (idle_mode == IDLE_BREATHE) begin
        phase = ((step_cnt % BREATHE_TICKS) * 64) / BREATHE_TICKS;
        if (phase > 32) phase = 64 - phase;
        fill_frame(scale_rgb(idle_color, BREATHE_CURVE[phase * 9 +: 9]));
      end else if (idle_mode == IDLE_SOLID) begin
        fill_frame(idle_color);
      end else begin
        fill_frame(RGB_BLACK);
      end
    end
  endtask

  // watch all three channels on every edge
  always @(posedge clk) begin : watch
    ring_pixel_t got;
    ring_pixel_t want;
    logic [31:0] now;
    logic [2:0]  code;
    logic [23:0] color;
    logic [7:0]  pct;
    if (!rst_n) begin
      hold_ms    = LEVEL_HOLD_RST;
      flash_half = FLASH_HALF_RST;
      error_half = ERROR_HALF_RST;
      step_cnt   = 32'd0;
      idle_mode  = IDLE_OFF;
      idle_color = RGB_BLACK;
      lvl_on     = 1'b0;
      lvl_val    = 7'd0;
      lvl_color  = RGB_BLACK;
      lvl_expiry = 32'd0;
      fb_mode    = FB_NONE;
      fb_color   = RGB_BLACK;
      fb_start   = 32'd0;
      fb_len     = 32'd0;
      fill_frame(RGB_BLACK);
      expected_pixels.delete();
      miss_cnt   = 0;
      mismatches <= 0;
      pending    <= 0;
    end else begin
      // pixel words against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.idx   = out_tdata[3:0];
        got.red   = out_tdata[11:4];
        got.green = out_tdata[19:12];
        got.blue  = out_tdata[27:20];
        got.last  = out_tlast;
        if (expected_pixels.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%0t unexpected pixel word: idx %0d rgb %02h %02h %02h last %0d",
                     $realtime, got.idx, got.red, got.green, got.blue, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display({"%0t pixel mismatch: expected idx %0d rgb %02h %02h %02h last %0d,",
                        " got idx %0d rgb %02h %02h %02h last %0d"},
                       $realtime, want.idx, want.red, want.green, want.blue, want.last,
                       got.idx, got.red, got.green, got.blue, got.last);
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEVEL_HOLD: hold_ms    = cfg_data;
          CFG_FLASH_HALF: flash_half = cfg_data[9:0];
          CFG_ERROR_HALF: error_half = cfg_data[9:0];
          default: ;
        endcase
      end

      // command words
      if (in_tvalid && in_tready) begin
        now   = in_tdata[31:0];
        code  = in_tdata[34:32];
        color = {in_tdata[42:35], in_tdata[50:43], in_tdata[58:51]};
        pct   = in_tdata[66:59];
        case (in_tuser)
          CMD_TICK: begin
            render_tick(now);
            push_frame();
          end
          CMD_SET_IDLE: begin
            idle_mode  = (code <= 3'(IDLE_SOLID)) ? idle_mode_t'(code[1:0]) : IDLE_OFF;
            idle_color = color;
            step_cnt   = 32'd0;
          end
          CMD_SHOW_LEVEL: begin
            lvl_on     = 1'b1;
            lvl_val    = (pct > LEVEL_MAX) ? LEVEL_MAX[6:0] : pct[6:0];
            lvl_color  = color;
            lvl_expiry = now + {16'd0, hold_ms};
          end
          CMD_FEEDBACK: begin
            fb_mode  = (code <= FB_ERROR) ? fb_mode_t'(code) : FB_NONE;
            fb_color = color;
            fb_start = now;
            fb_len   = in_tdata[98:67];
          end
          CMD_OFF: begin
            idle_mode  = IDLE_OFF;
            idle_color = RGB_BLACK;
            fill_frame(RGB_BLACK);
            push_frame();
          end
          default: ;
        endcase
      end

      mismatches <= miss_cnt;
      pending    <= expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_led_ring_animation_engine.sv =====
`timescale 1ns / 100ps

module tb_led_ring_animation_engine;
  import lra_pkg::*;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          LONG_HOLD     = 400;
  localparam int          PHASE_ITEMS   = 37;
  localparam logic [2:0]  CMD_BOGUS_LO  = 3'd5;
  localparam logic [2:0]  CMD_BOGUS_HI  = 3'd7;
  localparam logic [2:0]  ANIM_BOGUS    = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now;
    logic [2:0]  code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pct;
    logic [31:0] dur;
  } cmd_word_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [103:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = CMD_TICK;
  logic         out_tready = 1'b0;
  logic         cfg_valid  = 1'b0;
  logic [1:0]   cfg_index  = CFG_LEVEL_HOLD;
  logic [15:0]  cfg_data   = '0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [31:0] out_tdata;
  wire logic        out_tlast;
  wire logic        cfg_ready;
  int unsigned  mismatches;
  int unsigned  pending;

  int           burst_left    = 0;
  logic [31:0]  clock_ms      = 32'd0;
  bit           long_hold_req = 1'b0;
  bit           hold_taken    = 1'b0;
  int           ready_pct     = 100;
  int           cycle_cnt     = 0;

  led_ring_animation_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  led_ring_frame_checker i_frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[led_ring_animation_engine] ERROR");
    $finish;
  end

  // pixel receiver: stretches of varying readiness, one long hold-off on request
  initial begin
    forever begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 40;
        default: ready_pct = 15;
      endcase
      repeat ($urandom_range(4, 60)) begin
        @(posedge clk);
        if (long_hold_req && !hold_taken) begin
          hold_taken = 1'b1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        out_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  function automatic cmd_word_t word_of(input logic [2:0] cmd, input logic [31:0] now,
                                        input logic [2:0] code, input logic [23:0] rgb,
                                        input logic [7:0] pct, input logic [31:0] dur);
    cmd_word_t w;
    w.cmd   = cmd;
    w.now   = now;
    w.code  = code;
    w.red   = rgb[23:16];
    w.green = rgb[15:8];
    w.blue  = rgb[7:0];
    w.pct   = pct;
    w.dur   = dur;
    return w;
  endfunction

  // offer one command word, with random gaps between bursts
  task automatic send_word(input cmd_word_t w);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tdata  <= {5'b0, w.dur, w.pct, w.blue, w.green, w.red, w.code, w.now};
    in_tuser  <= w.cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop offering and wait for every pixel plus the divider latency
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random command word; time mostly moves forward in small steps
  task automatic next_word(input int tick_pct, output cmd_word_t w);
    int roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 40);
    w.now   = clock_ms;
    w.code  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    w.red   = 8'($urandom);
    w.green = 8'($urandom);
    w.blue  = 8'($urandom);
    w.pct   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 100)) : 8'($urandom);
    w.dur   = ($urandom_range(0, 99) < 85) ? 32'($urandom_range(0, 1500)) : 32'($urandom);
    if (roll < tick_pct)                                 w.cmd = CMD_TICK;
    else if (roll < tick_pct + (100 - tick_pct) * 1 / 4) w.cmd = CMD_SET_IDLE;
    else if (roll < tick_pct + (100 - tick_pct) * 2 / 4) w.cmd = CMD_SHOW_LEVEL;
    else if (roll < tick_pct + (100 - tick_pct) * 3 / 4) w.cmd = CMD_FEEDBACK;
    else if (roll < 97)                                  w.cmd = CMD_OFF;
    else w.cmd = 3'($urandom_range(CMD_BOGUS_LO, CMD_BOGUS_HI));
  endtask

  initial begin : stimulus
    cmd_word_t w;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset frame, idle modes, level, each feedback, off, unknown codes
    send_word(word_of(CMD_TICK,       32'd0,   FB_NONE,          24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_SET_IDLE,   32'd10,  3'(IDLE_BREATHE), 24'hFF8001, 8'd0,   32'd0));
    send_word(word_of(CMD_TICK,       32'd20,  FB_NONE,          24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_SET_IDLE,   32'd30,  ANIM_BOGUS,       24'hFFFFFF, 8'd0,   32'd0));
    send_word(word_of(CMD_TICK,       32'd40,  FB_NONE,          24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_SET_IDLE,   32'd50,  3'(IDLE_SOLID),   24'hFFFFFF, 8'd0,   32'd0));
    send_word(word_of(CMD_SHOW_LEVEL, 32'd100, FB_NONE,          24'h123456, 8'd255, 32'd0));
    send_word(word_of(CMD_TICK,       32'd110, FB_NONE,          24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_SHOW_LEVEL, 32'd120, FB_NONE,          24'hFFFFFF, 8'd0,   32'd0));
    send_word(word_of(CMD_TICK,       32'd130, FB_NONE,          24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd200, FB_CW,        24'hFFFFFF, 8'd0,   32'd1000));
    send_word(word_of(CMD_TICK,       32'd210, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd220, FB_CCW,       24'h80FF01, 8'd0,   32'd1000));
    send_word(word_of(CMD_TICK,       32'd230, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd300, FB_FLASH,     24'hABCDEF, 8'd0,   32'd1000));
    send_word(word_of(CMD_TICK,       32'd430, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd500, FB_ERROR,     24'h000000, 8'd0,   32'hFFFFFFFF));
    send_word(word_of(CMD_TICK,       32'd520, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd530, ANIM_BOGUS,   24'hFFFFFF, 8'd0,   32'd100));
    send_word(word_of(CMD_TICK,       32'd540, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_FEEDBACK,   32'd550, FB_CW,        24'hFFFFFF, 8'd0,   32'd0));
    send_word(word_of(CMD_TICK,       32'd560, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_OFF,        32'd570, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_BOGUS_LO,   32'd580, FB_NONE,      24'h000000, 8'd0,   32'd0));
    send_word(word_of(CMD_BOGUS_HI,   32'hFFFFFFFF, ANIM_BOGUS, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF));
    // level expiry across the time wrap
    send_word(word_of(CMD_SHOW_LEVEL, 32'hFFFFFF00, FB_NONE, 24'h00FF00, 8'd50, 32'd0));
    send_word(word_of(CMD_TICK,       32'hFFFFFFF0, FB_NONE, 24'h000000, 8'd0,  32'd0));
    send_word(word_of(CMD_TICK,       32'h00000800, FB_NONE, 24'h000000, 8'd0,  32'd0));
    settle();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_LEVEL_HOLD, 16'd0);
          write_reg(CFG_FLASH_HALF, 16'd1);
          write_reg(CFG_ERROR_HALF, 16'd1);
        end
        1: begin
          write_reg(CFG_LEVEL_HOLD, 16'd65535);
          write_reg(CFG_FLASH_HALF, 16'd1023);
          write_reg(CFG_ERROR_HALF, 16'd1023);
        end
        2: begin
          write_reg(CFG_LEVEL_HOLD, 16'd300);
          write_reg(CFG_FLASH_HALF, 16'd0);
          write_reg(CFG_ERROR_HALF, 16'd0);
          clock_ms = 32'hFFFF_FE00;
        end
        3: begin
          write_reg(CFG_LEVEL_HOLD, LEVEL_HOLD_RST);
          write_reg(CFG_FLASH_HALF, 16'(FLASH_HALF_RST));
          write_reg(CFG_ERROR_HALF, 16'(ERROR_HALF_RST));
        end
        default: begin
          write_reg(CFG_LEVEL_HOLD, 16'($urandom_range(0, 65535)));
          write_reg(CFG_FLASH_HALF, 16'($urandom_range(1, 1023)));
          write_reg(CFG_ERROR_HALF, 16'($urandom_range(1, 1023)));
        end
      endcase
      // back-pressure: receiver holds off while words keep coming without gaps
      if (ph == 1) begin
        long_hold_req = 1'b1;
        burst_left    = 40;
      end
      repeat (PHASE_ITEMS) begin
        next_word((ph == 1 || ph == 3) ? 80 : 50, w);
        send_word(w);
      end
      settle();
    end

    if (mismatches == 0 && pending == 0)
      $display("[led_ring_animation_engine] OK");
    else
      $display("[led_ring_animation_engine] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lra_pkg.sv
hdl/lra_div.sv
hdl/lra_front.sv
hdl/lra_fifo.sv
hdl/lra_back.sv
hdl/led_ring_animation_engine.sv
tb/led_ring_frame_checker.sv
tb/tb_led_ring_animation_engine.sv
